@@ sv/scs_pkg.sv @@
`default_nettype none
package scs_pkg;

    localparam int MAX_GROUP   = 64;
    localparam int GRP_AW      = $clog2(MAX_GROUP);
    localparam int CNT_W       = GRP_AW + 1;
    localparam int STRIP_W     = 12;
    localparam int CHG_W       = 17;
    localparam int POS_W       = 16;
    localparam int BIN_W       = 4;
    localparam int TOT_W       = 23;
    localparam int PROD_W      = POS_W + CHG_W + 1;
    localparam int NUM_W       = POS_W + CHG_W + GRP_AW;
    localparam int REM_W       = NUM_W + 1;
    localparam int QUO_W       = 16;
    localparam int QCNT_W      = $clog2(QUO_W);
    localparam int MAX_RESULTS = 64;
    localparam int MIN_SPLIT   = 3;

    localparam logic [1:0] REG_GAP   = 2'd0;
    localparam logic [1:0] REG_SPLIT = 2'd1;
    localparam logic [1:0] REG_MIN   = 2'd2;
    localparam logic [1:0] REG_MAX   = 2'd3;

    typedef struct packed {
        logic [STRIP_W-1:0]      strip_index;
        logic [CHG_W-1:0]        charge;
        logic signed [POS_W-1:0] position;
        logic [BIN_W-1:0]        sample_bin;
        logic                    end_of_plane;
    } t_in_item;

    typedef struct packed {
        logic signed [POS_W-1:0] cluster_position;
        logic [TOT_W-1:0]        charge_sum;
        logic [CHG_W-1:0]        charge_max;
        logic [BIN_W-1:0]        peak_bin;
        logic                    peak_valid;
        logic [CNT_W-1:0]        cluster_size;
        logic                    run_end;
        logic                    overflow;
    } t_out_item;

    typedef struct packed {
        logic [5:0]       gap_threshold;
        logic [CHG_W-1:0] split_threshold;
        logic [6:0]       min_cluster_size;
        logic [6:0]       max_cluster_size;
    } t_cfg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_STORE,
        OP_CLOSE_INIT,
        OP_TOP,
        OP_SCAN_RD,
        OP_SCAN_USE,
        OP_HALF,
        OP_ACC_INIT,
        OP_ACC_RD,
        OP_ACC_MUL,
        OP_ACC_ADD,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_EMIT,
        OP_NEXT,
        OP_CLOSE_DONE,
        OP_FINISH
    } t_op;

    typedef struct packed {
        t_op  op;
        logic ovf;
    } t_cmd;

    typedef struct packed {
        logic close_req;
        logic close_ovf;
        logic eop;
        logic short_part;
        logic valley;
        logic scan_last;
        logic acc_last;
        logic keep;
        logic div_last;
        logic last_part;
        logic emit_ready;
    } t_status;

endpackage
`default_nettype wire

@@ sv/scs_datapath.sv @@
`default_nettype none
module scs_datapath (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  scs_pkg::t_cmd        i_cmd,
    input  scs_pkg::t_cfg        i_cfg,
    input  scs_pkg::t_in_item    i_item,
    input  wire                  i_out_stall,
    output scs_pkg::t_status     o_status,
    output logic                 o_out_valid,
    output scs_pkg::t_out_item   o_out_data
);
    import scs_pkg::*;

    // Group buffer, one array per field, one address shared for reads.
    logic [CHG_W-1:0]        mem_q [MAX_GROUP];
    logic signed [POS_W-1:0] mem_p [MAX_GROUP];
    logic [BIN_W-1:0]        mem_b [MAX_GROUP];

    t_in_item                r_item;
    logic [CNT_W-1:0]        r_cnt;
    logic [STRIP_W-1:0]      r_prev_strip;
    logic [CNT_W-1:0]        r_start, r_end, r_idx, r_n;
    logic                    r_last, r_ovf, r_desc;
    logic [GRP_AW-1:0]       r_min;
    logic [CHG_W-1:0]        r_minc, r_prev;
    logic [CHG_W-1:0]        r_rd_q;
    logic signed [POS_W-1:0] r_rd_p;
    logic [BIN_W-1:0]        r_rd_b;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_prod_v;
    logic [TOT_W-1:0]        r_total;
    logic signed [NUM_W-1:0] r_num;
    logic [CHG_W-1:0]        r_peak;
    logic [BIN_W-1:0]        r_pbin;
    logic                    r_pvalid;
    logic                    r_neg;
    logic [REM_W-1:0]        r_rem, r_dvs;
    logic [QUO_W-1:0]        r_quo;
    logic [QCNT_W-1:0]       r_dcnt;
    t_out_item               r_pend, r_out;
    logic                    r_pend_valid, r_out_valid;

    logic signed [STRIP_W:0] step;
    logic                    gap_break;
    logic [CNT_W-1:0]        size;
    logic [CHG_W:0]          prev_plus_thr, cur_plus_thr;
    logic                    out_free, div_ge;
    logic [NUM_W-1:0]        mag;
    logic [QUO_W-1:0]        quo_neg;
    t_out_item               result;
    t_out_item               pend_last;
    logic                    wr_q_en;
    logic [GRP_AW-1:0]       wr_addr;
    logic [CHG_W-1:0]        wr_q_data;

    assign step      = $signed({1'b0, r_item.strip_index}) - $signed({1'b0, r_prev_strip});
    assign gap_break = step > $signed({{(STRIP_W-5){1'b0}}, i_cfg.gap_threshold});
    assign size      = r_end - r_start;
    assign prev_plus_thr = {1'b0, r_prev} + {1'b0, i_cfg.split_threshold};
    assign cur_plus_thr  = {1'b0, r_rd_q} + {1'b0, i_cfg.split_threshold};
    assign out_free  = !r_out_valid || !i_out_stall;
    assign div_ge    = r_rem >= r_dvs;
    assign mag       = r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
    assign quo_neg   = ~r_quo + QUO_W'(1);

    always_comb begin
        o_status.close_req  = (r_cnt != '0) && (gap_break || r_cnt >= CNT_W'(MAX_GROUP));
        o_status.close_ovf  = !gap_break;
        o_status.eop        = r_item.end_of_plane;
        o_status.short_part = (r_cnt - r_start) < CNT_W'(MIN_SPLIT);
        o_status.valley     = (r_idx != r_start) && r_desc && ({1'b0, r_rd_q} > prev_plus_thr);
        o_status.scan_last  = r_idx == (r_cnt - CNT_W'(1));
        o_status.acc_last   = r_idx == (r_end - CNT_W'(1));
        o_status.keep       = (size >= i_cfg.min_cluster_size)
                              && (size <= i_cfg.max_cluster_size)
                              && (r_n < CNT_W'(MAX_RESULTS));
        o_status.div_last   = r_dcnt == '0;
        o_status.last_part  = r_last;
        o_status.emit_ready = !r_pend_valid || out_free;
    end

    always_comb begin
        result.cluster_position = '0;
        if (r_total != '0) begin
            result.cluster_position = r_neg ? quo_neg : r_quo;
        end
        result.charge_sum   = r_total;
        result.charge_max   = r_peak;
        result.peak_bin     = r_pbin;
        result.peak_valid   = r_pvalid;
        result.cluster_size = size;
        result.run_end      = 1'b0;
        result.overflow     = r_ovf;
    end

    // The pending result as it leaves when it is the last one of a transfer.
    always_comb begin
        pend_last         = r_pend;
        pend_last.run_end = 1'b1;
    end

    // Buffer write port: a new strip, or the halved charge of a valley.
    always_comb begin
        wr_q_en   = (i_cmd.op == OP_STORE) || (i_cmd.op == OP_HALF);
        wr_addr   = (i_cmd.op == OP_HALF) ? r_min : r_cnt[GRP_AW-1:0];
        wr_q_data = (i_cmd.op == OP_HALF) ? (r_minc >> 1) : r_item.charge;
    end

    always_ff @(posedge i_clk) begin
        if (wr_q_en) begin
            mem_q[wr_addr] <= wr_q_data;
        end
        if (i_cmd.op == OP_STORE) begin
            mem_p[wr_addr] <= r_item.position;
            mem_b[wr_addr] <= r_item.sample_bin;
        end
        if (i_cmd.op == OP_SCAN_RD || i_cmd.op == OP_ACC_RD) begin
            r_rd_q <= mem_q[r_idx[GRP_AW-1:0]];
            r_rd_p <= mem_p[r_idx[GRP_AW-1:0]];
            r_rd_b <= mem_b[r_idx[GRP_AW-1:0]];
        end
    end

    // Payload and working registers.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_item <= i_item;
            end
            OP_CLOSE_INIT: begin
                r_start <= '0;
                r_ovf   <= i_cmd.ovf;
            end
            OP_TOP: begin
                r_idx  <= r_start;
                r_desc <= 1'b0;
                r_end  <= r_cnt;
                r_last <= 1'b1;
            end
            OP_SCAN_USE: begin
                if (r_idx != r_start) begin
                    if (r_desc) begin
                        if (r_prev < r_minc) begin
                            r_min  <= GRP_AW'(r_idx - CNT_W'(1));
                            r_minc <= r_prev;
                        end
                    end else if ({1'b0, r_prev} > cur_plus_thr) begin
                        r_desc <= 1'b1;
                        r_min  <= r_idx[GRP_AW-1:0];
                        r_minc <= r_rd_q;
                    end
                end
                r_prev <= r_rd_q;
                r_idx  <= r_idx + CNT_W'(1);
            end
            OP_HALF: begin
                r_end  <= {1'b0, r_min};
                r_last <= 1'b0;
            end
            OP_ACC_INIT: begin
                r_idx    <= r_start;
                r_total  <= '0;
                r_num    <= '0;
                r_peak   <= '0;
                r_pbin   <= '0;
                r_pvalid <= 1'b0;
                r_prod_v <= 1'b0;
            end
            OP_ACC_RD: begin
                if (r_prod_v) begin
                    r_num <= r_num + NUM_W'(r_prod);
                end
                r_prod_v <= 1'b0;
            end
            OP_ACC_MUL: begin
                r_prod   <= r_rd_p * $signed({1'b0, r_rd_q});
                r_prod_v <= 1'b1;
                r_total  <= r_total + TOT_W'(r_rd_q);
                if (r_rd_q > r_peak) begin
                    r_peak   <= r_rd_q;
                    r_pbin   <= r_rd_b;
                    r_pvalid <= 1'b1;
                end
                r_idx <= r_idx + CNT_W'(1);
            end
            OP_ACC_ADD: begin
                r_num    <= r_num + NUM_W'(r_prod);
                r_prod_v <= 1'b0;
            end
            OP_DIV_INIT: begin
                r_neg  <= r_num[NUM_W-1];
                r_rem  <= {mag, 1'b0} + REM_W'(r_total);
                r_dvs  <= {1'b0, r_total, 1'b0, {(QUO_W-1){1'b0}}};
                r_quo  <= '0;
                r_dcnt <= QCNT_W'(QUO_W - 1);
            end
            OP_DIV_STEP: begin
                if (div_ge) begin
                    r_rem <= r_rem - r_dvs;
                end
                r_quo  <= {r_quo[QUO_W-2:0], div_ge};
                r_dvs  <= r_dvs >> 1;
                r_dcnt <= r_dcnt - QCNT_W'(1);
            end
            OP_EMIT: begin
                r_pend <= result;
            end
            OP_NEXT: begin
                r_start <= r_end;
            end
            default: begin
            end
        endcase
        if (i_cmd.op == OP_EMIT && r_pend_valid) begin
            r_out <= r_pend;
        end else if (i_cmd.op == OP_FINISH && r_pend_valid) begin
            r_out <= pend_last;
        end
    end

    // Control state: fill count, last strip, result bookkeeping, output flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_prev_strip <= '0;
            r_n          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.op == OP_LOAD) begin
                r_n <= '0;
            end
            if (i_cmd.op == OP_STORE) begin
                r_cnt        <= r_cnt + CNT_W'(1);
                r_prev_strip <= r_item.strip_index;
            end
            if (i_cmd.op == OP_CLOSE_DONE) begin
                r_cnt <= '0;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_n          <= r_n + CNT_W'(1);
                r_pend_valid <= 1'b1;
            end
            if (i_cmd.op == OP_FINISH) begin
                r_pend_valid <= 1'b0;
            end
            if ((i_cmd.op == OP_EMIT || i_cmd.op == OP_FINISH) && r_pend_valid) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

@@ sv/scs_ctrl.sv @@
`default_nettype none
module scs_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_accept,
    input  scs_pkg::t_status i_status,
    output scs_pkg::t_cmd    o_cmd,
    output logic             o_busy
);
    import scs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_STORE, S_CLOSE, S_TOP, S_SCAN_RD, S_SCAN_USE, S_HALF,
        S_ACC_INIT, S_ACC_RD, S_ACC_MUL, S_ACC_ADD, S_DIV_INIT, S_DIV, S_EMIT,
        S_NEXT
    } t_state;

    t_state r_state, n_state;
    logic   r_after, n_after;         // 1: finish the transfer after the close
    logic   r_close_ovf, n_close_ovf;
    logic   r_finish, n_finish;       // final flush of the pending result

    always_comb begin
        n_state     = r_state;
        n_after     = r_after;
        n_close_ovf = r_close_ovf;
        n_finish    = r_finish;
        o_cmd.op    = OP_NONE;
        o_cmd.ovf   = r_close_ovf;
        if (r_finish) begin
            if (i_status.emit_ready) begin
                o_cmd.op = OP_FINISH;
                n_finish = 1'b0;
                n_state  = S_IDLE;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_accept) begin
                        o_cmd.op = OP_LOAD;
                        n_state  = S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (i_status.close_req) begin
                        n_close_ovf = i_status.close_ovf;
                        n_after     = 1'b0;
                        n_state     = S_CLOSE;
                    end else begin
                        n_state = S_STORE;
                    end
                end
                S_STORE: begin
                    o_cmd.op = OP_STORE;
                    if (i_status.eop) begin
                        n_close_ovf = 1'b0;
                        n_after     = 1'b1;
                        n_state     = S_CLOSE;
                    end else begin
                        n_finish = 1'b1;
                    end
                end
                S_CLOSE: begin
                    o_cmd.op = OP_CLOSE_INIT;
                    n_state  = S_TOP;
                end
                S_TOP: begin
                    o_cmd.op = OP_TOP;
                    n_state  = i_status.short_part ? S_ACC_INIT : S_SCAN_RD;
                end
                S_SCAN_RD: begin
                    o_cmd.op = OP_SCAN_RD;
                    n_state  = S_SCAN_USE;
                end
                S_SCAN_USE: begin
                    o_cmd.op = OP_SCAN_USE;
                    if (i_status.valley) begin
                        n_state = S_HALF;
                    end else if (i_status.scan_last) begin
                        n_state = S_ACC_INIT;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
                S_HALF: begin
                    o_cmd.op = OP_HALF;
                    n_state  = S_ACC_INIT;
                end
                S_ACC_INIT: begin
                    o_cmd.op = OP_ACC_INIT;
                    n_state  = S_ACC_RD;
                end
                S_ACC_RD: begin
                    o_cmd.op = OP_ACC_RD;
                    n_state  = S_ACC_MUL;
                end
                S_ACC_MUL: begin
                    o_cmd.op = OP_ACC_MUL;
                    n_state  = i_status.acc_last ? S_ACC_ADD : S_ACC_RD;
                end
                S_ACC_ADD: begin
                    o_cmd.op = OP_ACC_ADD;
                    n_state  = i_status.keep ? S_DIV_INIT : S_NEXT;
                end
                S_DIV_INIT: begin
                    o_cmd.op = OP_DIV_INIT;
                    n_state  = S_DIV;
                end
                S_DIV: begin
                    o_cmd.op = OP_DIV_STEP;
                    if (i_status.div_last) begin
                        n_state = S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (i_status.emit_ready) begin
                        o_cmd.op = OP_EMIT;
                        n_state  = S_NEXT;
                    end
                end
                S_NEXT: begin
                    if (i_status.last_part) begin
                        o_cmd.op = OP_CLOSE_DONE;
                        if (r_after) begin
                            n_finish = 1'b1;
                        end else begin
                            n_state = S_STORE;
                        end
                    end else begin
                        o_cmd.op = OP_NEXT;
                        n_state  = S_TOP;
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_after     <= 1'b0;
            r_close_ovf <= 1'b0;
            r_finish    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_after     <= n_after;
            r_close_ovf <= n_close_ovf;
            r_finish    <= n_finish;
        end
    end

    assign o_busy = (r_state != S_IDLE) || r_finish;

endmodule
`default_nettype wire

@@ sv/strip_cluster_splitter.sv @@
// A strip that closes nothing needs no group work; closing a group runs, for each part, a
// valley scan over its strips unless the part is short, its sums and, if it is reported, a
// centroid divide (one quotient bit per cycle). A strip is taken only once the previous
// one is done. Reset (i_rst_n, synchronous, active low) empties the group and restores
// the register defaults; the group buffer itself is not cleared.
`default_nettype none
module strip_cluster_splitter (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    output logic                 o_in_stall,
    input  scs_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  wire                  i_out_stall,
    output scs_pkg::t_out_item   o_out_data,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [3:0]           paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import scs_pkg::*;

    // Configuration registers, one 32-bit word each.
    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;
    logic    busy;
    logic    in_accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gap_threshold    <= 6'd1;
            r_cfg.split_threshold  <= CHG_W'(28);
            r_cfg.min_cluster_size <= 7'd1;
            r_cfg.max_cluster_size <= 7'd20;
        end else if (psel && penable && pwrite) begin
            case (paddr[3:2])
                REG_GAP:   r_cfg.gap_threshold    <= pwdata[5:0];
                REG_SPLIT: r_cfg.split_threshold  <= pwdata[CHG_W-1:0];
                REG_MIN:   r_cfg.min_cluster_size <= pwdata[6:0];
                REG_MAX:   r_cfg.max_cluster_size <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_GAP:   prdata = 32'(r_cfg.gap_threshold);
            REG_SPLIT: prdata = 32'(r_cfg.split_threshold);
            REG_MIN:   prdata = 32'(r_cfg.min_cluster_size);
            REG_MAX:   prdata = 32'(r_cfg.max_cluster_size);
            default:   prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // A strip transfer is taken only while the controller sits idle and the
    // block is out of reset.
    assign o_in_stall = busy || !i_rst_n;
    assign in_accept  = i_in_valid && !o_in_stall;

    // The controller walks the group: valley scan, part sums, divide, then
    // hands each part to a one-deep pending slot so the last result of a
    // transfer can be marked before it leaves through the output register.
    scs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    scs_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (r_cfg),
        .i_item      (i_in_data),
        .i_out_stall (i_out_stall),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

@@ tb/tb.sv @@
`default_nettype none
module tb;
    import scs_pkg::*;

    // Clock and reset.
    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Block ports. Every input starts at a known value.
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    strip_cluster_splitter dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Predictor state: our own copy of the registers and of the open group.
    logic [5:0]       gap_thr;
    logic [CHG_W-1:0] split_thr;
    logic [6:0]       min_size;
    logic [6:0]       max_size;
    logic [CHG_W-1:0] grp_charge [MAX_GROUP];
    logic signed [POS_W-1:0] grp_pos [MAX_GROUP];
    logic [BIN_W-1:0] grp_bin [MAX_GROUP];
    int               grp_count;
    int               last_strip;

    t_in_item  strip_queue[$];
    t_out_item cluster_queue[$];

    int  failures = 0;
    int  strips_sent = 0;
    int  clusters_seen = 0;
    int  overflow_seen = 0;
    bit  quiet = 1'b0;   // no idling in the last part of the run

    // Handshake state seen at the last rising edge.
    logic in_stall_q = 1'b1;
    int   in_idle = 0;
    int   out_idle = 0;
    int   watchdog = 0;

    // Appends one strip to the pending stimulus.
    task automatic add_strip(input t_in_item s);
        strip_queue.insert(strip_queue.size(), s);
    endtask

    // Builds the expected record of one part of the group, [first, last), if its size lies
    // within the limits and the result cap is not reached, and appends it to the expected results.
    task automatic add_part(input int first, input int last, input bit ovf,
                            inout int n);
        t_out_item r;
        longint    total;
        longint    num;
        longint    mag;
        longint    quo;
        int        size;
        size = last - first;
        if (size < min_size || size > max_size || n >= MAX_RESULTS) return;
        r = '0;
        total = 0;
        num = 0;
        for (int i = first; i < last; i++) begin
            if (grp_charge[i] > r.charge_max) begin
                r.charge_max = grp_charge[i];
                r.peak_bin = grp_bin[i];
                r.peak_valid = 1'b1;
            end
            total += grp_charge[i];
            num += longint'(grp_pos[i]) * longint'(grp_charge[i]);
        end
        if (total > 0) begin
            mag = (num < 0) ? -num : num;
            quo = (mag * 2 + total) / (2 * total);
            r.cluster_position = POS_W'((num < 0) ? -quo : quo);
        end
        if (total > 64'd8388607) total = 8388607;
        r.charge_sum = TOT_W'(total);
        r.cluster_size = CNT_W'(size);
        r.overflow = ovf;
        cluster_queue.insert(cluster_queue.size(), r);
        n++;
    endtask

    // Closes the open group: splits it at valleys and predicts each part.
    task automatic close_group(input bit ovf, inout int n);
        int  start;
        int  lowest;
        bit  falling;
        bit  found;
        start = 0;
        while (grp_count > start) begin
            falling = 1'b0;
            found = 1'b0;
            lowest = start;
            if (grp_count - start < MIN_SPLIT) begin
                add_part(start, grp_count, ovf, n);
                break;
            end
            for (int k = start; k + 1 < grp_count; k++) begin
                if (falling) begin
                    if (grp_charge[k] < grp_charge[lowest]) lowest = k;
                    if (longint'(grp_charge[k+1]) - longint'(grp_charge[k])
                            > longint'(split_thr)) begin
                        found = 1'b1;
                        break;
                    end
                end else if (longint'(grp_charge[k]) - longint'(grp_charge[k+1])
                             > longint'(split_thr)) begin
                    falling = 1'b1;
                    lowest = k + 1;
                end
            end
            if (!found) begin
                add_part(start, grp_count, ovf, n);
                break;
            end
            // The valley strip keeps half its charge and opens the next part.
            grp_charge[lowest] = grp_charge[lowest] >> 1;
            add_part(start, lowest, ovf, n);
            start = lowest;
        end
        grp_count = 0;
    endtask

    // Predicts the clusters caused by one accepted strip.
    task automatic predict_strip(input t_in_item s);
        int n;
        int base;
        n = 0;
        base = cluster_queue.size();
        if (grp_count > 0) begin
            if (int'(s.strip_index) - last_strip > int'(gap_thr))
                close_group(1'b0, n);
            else if (grp_count >= MAX_GROUP)
                close_group(1'b1, n);
        end
        grp_charge[grp_count] = s.charge;
        grp_pos[grp_count] = s.position;
        grp_bin[grp_count] = s.sample_bin;
        grp_count++;
        last_strip = int'(s.strip_index);
        if (s.end_of_plane) close_group(1'b0, n);
        if (n > 0) cluster_queue[base + n - 1].run_end = 1'b1;
    endtask

    // Starts an idle burst now and then; returns whether one began.
    function automatic bit pick_idle();
        if (quiet || $urandom_range(0, 9) != 0) return 1'b0;
        in_idle = $urandom_range(1, 8) - 1;
        return 1'b1;
    endfunction

    // Driver: one pending strip at a time, with random idle bursts.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !in_stall_q) begin
                // The previous transfer completed at the rising edge.
                if (strip_queue.size() > 0 && in_idle == 0 && !pick_idle()) begin
                    in_data <= strip_queue.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end else if (!in_valid) begin
                if (in_idle > 0) begin
                    in_idle--;
                end else if (strip_queue.size() > 0 && !pick_idle()) begin
                    in_data <= strip_queue.pop_front();
                    in_valid <= 1'b1;
                end
            end
        end
    end

    // Monitor: samples both channels at the rising edge.
    always @(posedge i_clk) begin
        in_stall_q <= !(in_valid && !in_stall);
        if (i_rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                watchdog <= 0;
            end else begin
                watchdog <= watchdog + 1;
            end
            if (in_valid && !in_stall) begin
                predict_strip(in_data);
                strips_sent <= strips_sent + 1;
            end
            if (out_valid && !out_stall) begin
                clusters_seen <= clusters_seen + 1;
                if (out_data.overflow) overflow_seen <= overflow_seen + 1;
                check_cluster(out_data);
            end
            if (watchdog > 20000) begin
                $display("watchdog expired with %0d clusters outstanding",
                         cluster_queue.size());
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // Receiver stall, changed at the falling edge in random bursts.
    always @(negedge i_clk) begin
        if (out_idle > 0) begin
            out_idle--;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            out_stall <= 1'b1;
            out_idle = $urandom_range(1, 8);
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic check_cluster(input t_out_item got);
        t_out_item want;
        if (cluster_queue.size() == 0) begin
            $error("cluster with no expectation: %p", got);
            failures++;
            return;
        end
        want = cluster_queue.pop_front();
        if (got.cluster_position !== want.cluster_position) begin
            $error("cluster_position expected %0d got %0d",
                   want.cluster_position, got.cluster_position);
            failures++;
        end
        if (got.charge_sum !== want.charge_sum) begin
            $error("charge_sum expected %0d got %0d", want.charge_sum, got.charge_sum);
            failures++;
        end
        if (got.charge_max !== want.charge_max) begin
            $error("charge_max expected %0d got %0d", want.charge_max, got.charge_max);
            failures++;
        end
        if (got.peak_bin !== want.peak_bin) begin
            $error("peak_bin expected %0d got %0d", want.peak_bin, got.peak_bin);
            failures++;
        end
        if (got.peak_valid !== want.peak_valid) begin
            $error("peak_valid expected %0d got %0d", want.peak_valid, got.peak_valid);
            failures++;
        end
        if (got.cluster_size !== want.cluster_size) begin
            $error("cluster_size expected %0d got %0d",
                   want.cluster_size, got.cluster_size);
            failures++;
        end
        if (got.run_end !== want.run_end) begin
            $error("run_end expected %0d got %0d", want.run_end, got.run_end);
            failures++;
        end
        if (got.overflow !== want.overflow) begin
            $error("overflow expected %0d got %0d", want.overflow, got.overflow);
            failures++;
        end
    endtask

    // Register write: setup cycle then access cycle, changed at falling edges.
    // The predictor copy is updated at the same edge the block takes the write,
    // and the register is read back once the write has landed.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        logic [31:0] rb;
        @(negedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_GAP: begin
                gap_thr = value[5:0];
                rb = 32'(value[5:0]);
            end
            REG_SPLIT: begin
                split_thr = value[CHG_W-1:0];
                rb = 32'(value[CHG_W-1:0]);
            end
            REG_MIN: begin
                min_size = value[6:0];
                rb = 32'(value[6:0]);
            end
            REG_MAX: begin
                max_size = value[6:0];
                rb = 32'(value[6:0]);
            end
            default: rb = '0;
        endcase
        @(negedge i_clk);
        if (prdata !== rb) begin
            $error("register readback expected %0d got %0d", rb, prdata);
            failures++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_all(input int g, input int s, input int lo, input int hi);
        write_reg(REG_GAP, g);
        write_reg(REG_SPLIT, s);
        write_reg(REG_MIN, lo);
        write_reg(REG_MAX, hi);
    endtask

    // Waits until every strip is taken and every cluster has arrived, then lets
    // the block settle, since a strip may still be at work causing nothing.
    task automatic drain();
        int guard;
        guard = 0;
        while ((strip_queue.size() > 0 || in_valid || cluster_queue.size() > 0)
               && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (3000) @(posedge i_clk);
    endtask

    function automatic t_in_item make_strip(input int idx, input int q, input int pos,
                                            input bit eop);
        t_in_item s;
        s.strip_index = STRIP_W'(idx);
        s.charge = CHG_W'(q);
        s.position = POS_W'(pos);
        s.sample_bin = BIN_W'($urandom_range(0, 15));
        s.end_of_plane = eop;
        return s;
    endfunction

    // Queues a plane of random clusters: short groups with peaks and valleys,
    // mostly with consecutive strips, closed by a flagged last strip.
    task automatic queue_plane(input int groups, input int qmax);
        int idx;
        int len;
        int q;
        idx = $urandom_range(0, 40);
        for (int g = 0; g < groups; g++) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 9);
            for (int k = 0; k < len && idx < 4095; k++) begin
                case ($urandom_range(0, 3))
                    0: q = $urandom_range(0, 60);
                    1: q = $urandom_range(0, qmax);
                    default: q = (k % 3 == 1) ? $urandom_range(0, 40)
                                              : $urandom_range(100, qmax);
                endcase
                add_strip(make_strip(idx, q, $urandom_range(0, 65535), 1'b0));
                // Mostly consecutive, sometimes a skip or a step backward.
                case ($urandom_range(0, 9))
                    0: idx = (idx > 3) ? idx - 2 : idx;
                    1: idx += 2;
                    default: idx += 1;
                endcase
            end
            idx += $urandom_range(2, 10);
            if (idx > 4000) idx = $urandom_range(0, 100);
        end
        add_strip(make_strip(idx > 4095 ? 4095 : idx, $urandom_range(0, qmax),
                             $urandom_range(0, 65535), 1'b1));
    endtask

    initial begin
        gap_thr = 6'd1;
        split_thr = CHG_W'(28);
        min_size = 7'd1;
        max_size = 7'd20;
        grp_count = 0;
        last_strip = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes of each field, a clean valley split, a plateau and
        // an all-zero cluster, a step backward, with gaps and plane-end flags closing the groups.
        add_strip(make_strip(0, 0, -32768, 1'b1));
        add_strip(make_strip(4095, 131071, 32767, 1'b1));
        add_strip(make_strip(10, 500, -100, 1'b0));
        add_strip(make_strip(11, 100, 0, 1'b0));
        add_strip(make_strip(12, 31, 64, 1'b0));
        add_strip(make_strip(13, 400, 128, 1'b0));
        add_strip(make_strip(14, 400, 192, 1'b0));
        add_strip(make_strip(16, 0, 300, 1'b0));
        add_strip(make_strip(15, 0, -300, 1'b0));
        add_strip(make_strip(17, 0, 5, 1'b1));
        add_strip(make_strip(20, 131071, -1, 1'b0));
        add_strip(make_strip(21, 7, -3, 1'b0));
        add_strip(make_strip(22, 131071, -5, 1'b0));
        add_strip(make_strip(40, 9, 7, 1'b1));
        drain();

        // Overflow: a run longer than the group buffer, with wide size limits.
        write_all(63, 0, 1, 64);
        for (int k = 0; k < 70; k++)
            add_strip(make_strip(100 + k, $urandom_range(0, 131071),
                                 $urandom_range(0, 65535), k == 69));
        drain();
        write_all(63, 131071, 64, 64);
        for (int k = 0; k < 65; k++)
            add_strip(make_strip(200 + k, 1000, k, k == 64));
        drain();
        // Minimum above maximum drops every cluster.
        write_all(0, 5, 7, 3);
        queue_plane(2, 2000);
        drain();

        // Random phases under several register settings.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: write_all(1, 28, 1, 20);
                1: write_all(0, 0, 1, 64);
                2: write_all($urandom_range(0, 63), $urandom_range(0, 131071),
                             $urandom_range(1, 4), $urandom_range(4, 64));
                3: write_all(2, $urandom_range(0, 300), 2, 10);
                4: write_all(1, 50, 1, 20);
                default: begin
                    write_all(3, 40, 1, 64);
                    quiet = 1'b1;
                end
            endcase
            queue_plane($urandom_range(1, 5), (ph % 2 == 0) ? 131071 : 3000);
            drain();
        end

        $display("%0d strips sent, %0d clusters checked (%0d from full groups)",
                 strips_sent, clusters_seen, overflow_seen);
        $display("six register settings covered, including zero and full-scale limits");
        if (failures == 0 && cluster_queue.size() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
`default_nettype wire
